// ===== design/tkr_pkg.sv =====
// Package for the top-K ratio ranker: field widths, commands, status codes,
// record type. Used by every file of the design except tkr_ram.
package tkr_pkg;

  localparam int LIST_SIZE_DEF = 100;
  localparam int RATIO_W = 23;
  localparam int ID_W = 24;
  localparam int PER_W = 8;
  localparam int VAL_W = 16;
  localparam int RANK_W = 7;
  localparam int REC_W = RATIO_W + 3 * ID_W + PER_W + 2 * VAL_W;
  localparam logic [6:0] RATIO_SCALE = 7'd100;

  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_VOL = 2'd1;
  localparam logic [1:0] ST_ZERO_CAP = 2'd2;
  localparam logic [1:0] ST_NOT_RANK = 2'd3;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [ID_W-1:0]    link_id;
    logic [ID_W-1:0]    from_node;
    logic [ID_W-1:0]    to_node;
    logic [PER_W-1:0]   period;
    logic [VAL_W-1:0]   volume;
    logic [VAL_W-1:0]   capacity;
  } rec_t;

endpackage

// ===== design/tkr_in_if.sv =====
// Channel interfaces of the ranker: offer/read/clear words in, result words out.
// Depends on tkr_pkg.
interface tkr_in_if import tkr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [ID_W-1:0]     link_id;
  logic [ID_W-1:0]     from_node;
  logic [ID_W-1:0]     to_node;
  logic [PER_W-1:0]    period;
  logic [VAL_W-1:0]    volume;
  logic [VAL_W-1:0]    capacity;
  logic [RANK_W-1:0]   rank;
  modport source (output valid, cmd, link_id, from_node, to_node, period, volume,
                  capacity, rank, input ready);
  modport sink (input valid, cmd, link_id, from_node, to_node, period, volume,
                capacity, rank, output ready);
endinterface

interface tkr_out_if import tkr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [RANK_W-1:0]   slot;
  logic                entry_valid;
  logic [RATIO_W-1:0]  ratio;
  logic [ID_W-1:0]     out_link;
  logic [ID_W-1:0]     out_from;
  logic [ID_W-1:0]     out_to;
  logic [PER_W-1:0]    out_period;
  logic [VAL_W-1:0]    out_volume;
  logic [VAL_W-1:0]    out_capacity;
  modport source (output valid, status, slot, entry_valid, ratio, out_link, out_from,
                  out_to, out_period, out_volume, out_capacity, input ready);
  modport sink (input valid, status, slot, entry_valid, ratio, out_link, out_from,
                out_to, out_period, out_volume, out_capacity, output ready);
endinterface

// ===== design/tkr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/tkr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the rounded ratio.
// Depends on tkr_pkg.
module tkr_div import tkr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RATIO_W-1:0] dividend,
  input  logic [VAL_W-1:0]   divisor,
  output logic               done,
  output logic [RATIO_W-1:0] quotient
);
  localparam int CNT_W = $clog2(RATIO_W + 1);

  logic [VAL_W:0]     rem;
  logic [RATIO_W-1:0] quo;
  logic [VAL_W-1:0]   dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [VAL_W+1:0]   trial;

  assign trial = {rem, quo[RATIO_W-1]} - {2'b00, dvs};
  assign done = busy && (cnt == CNT_W'(0));
  assign quotient = quo;

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(RATIO_W);
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy && cnt != CNT_W'(0)) begin
      cnt <= cnt - CNT_W'(1);
      if (!trial[VAL_W+1]) begin
        rem <= trial[VAL_W:0];
        quo <= {quo[RATIO_W-2:0], 1'b1};
      end else begin
        rem <= {rem[VAL_W-1:0], quo[RATIO_W-1]};
        quo <= {quo[RATIO_W-2:0], 1'b0};
      end
    end else if (done) begin
      busy <= 1'b0;
    end
  end
endmodule

// ===== design/top_k_ratio_ranker.sv =====
// Top-K ratio ranker: sorted list of records in one RAM, one divider for the offer ratio.
// Depends on tkr_pkg, tkr_in_if, tkr_out_if, tkr_ram, tkr_div.
//
//  channel  dir  word
//  in_ch    in   cmd, link_id, from_node, to_node, period, volume, capacity, rank
//  out_ch   out  status, slot, entry_valid, ratio, out_* record fields
//
// Offer: the bit-serial divider forms the ratio, then one RAM read per rank to
// find the slot and one read plus write per entry to shift the tail down.
// Read: one RAM read at the requested rank.
// Occupancy is a fill count (entries form a prefix), reset and clear zero it.
// One word at a time; input ready is low from accept until the result leaves.
module top_k_ratio_ranker import tkr_pkg::*; #(
  parameter int LIST_SIZE = LIST_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  tkr_in_if.sink    in_ch,
  tkr_out_if.source out_ch
);
  localparam int AW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int CW = $clog2(LIST_SIZE + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_READ  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  rec_t rec;
  logic [RANK_W-1:0] rank;
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  rec_t wdata, rdata;
  logic div_start, div_done;
  logic [RATIO_W-1:0] quo;
  logic rd_pend;
  logic [CW-1:0] pos;

  // result register
  logic [1:0] status;
  logic [RANK_W-1:0] slot;
  logic ev;
  logic [RATIO_W-1:0] ratio;
  rec_t orec;

  tkr_ram #(.WIDTH(REC_W), .DEPTH(LIST_SIZE)) u_ram (
    .clk, .we(ram_we), .waddr, .wdata, .raddr, .rdata
  );

  tkr_div u_div (
    .clk, .rst, .start(div_start),
    .dividend(RATIO_W'(in_ch.volume) * RATIO_W'(RATIO_SCALE)
              + RATIO_W'(in_ch.capacity >> 1)),
    .divisor(in_ch.capacity), .done(div_done), .quotient(quo)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign div_start = in_ch.valid && in_ch.ready && in_ch.cmd == CMD_OFFER
                     && in_ch.volume != '0 && in_ch.capacity != '0;

  // drive read address and write port from the sequencer
  always_comb begin
    raddr = idx[AW-1:0];
    ram_we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    if (state == S_SHIFT) begin
      raddr = AW'(idx - CW'(1));
      ram_we = rd_pend;
      waddr = idx[AW-1:0];
    end else if (state == S_WRITE) begin
      ram_we = 1'b1;
      waddr = pos[AW-1:0];
      wdata = rec;
    end else if (state == S_READ) begin
      raddr = AW'(rank);
    end else if (state == S_IDLE) begin
      raddr = AW'(in_ch.rank);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      out_ch.valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            rank <= in_ch.rank;
            rec.ratio <= '0;
            rec.link_id <= in_ch.link_id;
            rec.from_node <= in_ch.from_node;
            rec.to_node <= in_ch.to_node;
            rec.period <= in_ch.period;
            rec.volume <= in_ch.volume;
            rec.capacity <= in_ch.capacity;
            status <= ST_OK;
            slot <= '0;
            ev <= 1'b0;
            ratio <= '0;
            orec <= '0;
            case (in_ch.cmd)
              CMD_OFFER: begin
                if (in_ch.volume == '0) begin
                  status <= ST_ZERO_VOL;
                  state <= S_OUT;
                  out_ch.valid <= 1'b1;
                end else if (in_ch.capacity == '0) begin
                  status <= ST_ZERO_CAP;
                  state <= S_OUT;
                  out_ch.valid <= 1'b1;
                end else begin
                  state <= S_DIV;
                end
              end
              CMD_READ: begin
                slot <= in_ch.rank;
                if (32'(in_ch.rank) >= 32'(fill)) begin
                  status <= ST_NOT_RANK;
                  state <= S_OUT;
                  out_ch.valid <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              CMD_CLEAR: begin
                fill <= '0;
                state <= S_OUT;
                out_ch.valid <= 1'b1;
              end
              default: begin
                state <= S_OUT;
                out_ch.valid <= 1'b1;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            rec.ratio <= quo;
            ratio <= quo;
            idx <= '0;
            rd_pend <= 1'b0;
            if (quo == '0) begin
              status <= ST_NOT_RANK;
              state <= S_OUT;
              out_ch.valid <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        // read entry idx, compare in the cycle after
        S_SCAN: begin
          if (!rd_pend) begin
            if (idx == fill) begin
              if (fill == CW'(LIST_SIZE)) begin
                status <= ST_NOT_RANK;
                state <= S_OUT;
                out_ch.valid <= 1'b1;
              end else begin
                pos <= idx;
                state <= S_WRITE;
              end
            end else begin
              rd_pend <= 1'b1;
            end
          end else begin
            rd_pend <= 1'b0;
            if (rec.ratio > rdata.ratio) begin
              pos <= idx;
              idx <= (fill == CW'(LIST_SIZE)) ? CW'(LIST_SIZE - 1) : fill;
              state <= S_SHIFT;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        // move entry idx-1 to idx, from the tail up to the slot
        S_SHIFT: begin
          if (idx == pos) begin
            state <= S_WRITE;
            rd_pend <= 1'b0;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            idx <= idx - CW'(1);
          end
        end
        S_WRITE: begin
          if (fill != CW'(LIST_SIZE)) begin
            fill <= fill + CW'(1);
          end
          slot <= RANK_W'(pos);
          state <= S_OUT;
          out_ch.valid <= 1'b1;
        end
        // hold the read address on rank, take the word once rd_pend is set
        S_READ: begin
          if (rd_pend) begin
            rd_pend <= 1'b0;
            ev <= 1'b1;
            ratio <= rdata.ratio;
            orec <= rdata;
            state <= S_OUT;
            out_ch.valid <= 1'b1;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.status = status;
  assign out_ch.slot = slot;
  assign out_ch.entry_valid = ev;
  assign out_ch.ratio = ratio;
  assign out_ch.out_link = orec.link_id;
  assign out_ch.out_from = orec.from_node;
  assign out_ch.out_to = orec.to_node;
  assign out_ch.out_period = orec.period;
  assign out_ch.out_volume = orec.volume;
  assign out_ch.out_capacity = orec.capacity;

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= LIST_SIZE) else $error("fill beyond list size");
  a_ready_valid: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_ok_ratio: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.entry_valid |-> out_ch.ratio != '0)
    else $error("valid entry with zero ratio");
`endif
endmodule

// ===== bench/tb_tkr_ifs.sv =====
// Testbench copy point for the ranker channel interfaces.
// The interfaces themselves live in the design (tkr_in_if, tkr_out_if); this file
// holds the small word types the bench uses. Depends on tkr_pkg.
package tb_tkr_types;
  import tkr_pkg::*;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   link_id;
    logic [ID_W-1:0]   from_node;
    logic [ID_W-1:0]   to_node;
    logic [PER_W-1:0]  period;
    logic [VAL_W-1:0]  volume;
    logic [VAL_W-1:0]  capacity;
    logic [RANK_W-1:0] rank;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [RANK_W-1:0]  slot;
    logic               entry_valid;
    logic [RATIO_W-1:0] ratio;
    logic [ID_W-1:0]    out_link;
    logic [ID_W-1:0]    out_from;
    logic [ID_W-1:0]    out_to;
    logic [PER_W-1:0]   out_period;
    logic [VAL_W-1:0]   out_volume;
    logic [VAL_W-1:0]   out_capacity;
  } rsp_word_t;
endpackage

// ===== bench/tb_top_k_ratio_ranker.sv =====
// Self-checking bench for top_k_ratio_ranker: directed table, then random
// offers/reads/clears checked against a behavioral ranking list.
// Depends on tkr_pkg, tb_tkr_types, tkr_in_if, tkr_out_if and the design.
module tb_top_k_ratio_ranker;
  timeunit 1ns;
  timeprecision 1ps;
  import tkr_pkg::*;
  import tb_tkr_types::*;

  localparam int NLIST = LIST_SIZE_DEF;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic clk;
  logic rst;
  tkr_in_if  in_ch ();
  tkr_out_if out_ch ();

  top_k_ratio_ranker dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  // shadow list
  logic [RATIO_W-1:0] rank_ratio [NLIST];
  rec_t               rank_rec   [NLIST];
  int                 fill_cnt;
  rsp_word_t          pending_rsp [$];
  int                 err_cnt, rsp_cnt, word_cnt;
  int                 send_idle, recv_stall;
  bit                 check_row;
  rsp_word_t          row_rsp;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // compute the expected word and update the shadow list
  function automatic rsp_word_t rank_update(req_word_t w);
    rsp_word_t r;
    logic [31:0] q;
    int k;
    r = '0;
    if (w.cmd == CMD_OFFER) begin
      if (w.volume == 0) r.status = ST_ZERO_VOL;
      else if (w.capacity == 0) r.status = ST_ZERO_CAP;
      else begin
        q = (32'(w.volume) * 100 + 32'(w.capacity) / 2) / 32'(w.capacity);
        r.ratio = q[RATIO_W-1:0];
        for (k = 0; k < NLIST; k++) if (q > 32'(rank_ratio[k])) break;
        if (k >= NLIST) r.status = ST_NOT_RANK;
        else begin
          for (int i = NLIST - 1; i > k; i--) begin
            rank_ratio[i] = rank_ratio[i-1];
            rank_rec[i] = rank_rec[i-1];
          end
          rank_ratio[k] = q[RATIO_W-1:0];
          rank_rec[k] = '{q[RATIO_W-1:0], w.link_id, w.from_node, w.to_node,
                          w.period, w.volume, w.capacity};
          r.slot = k[RANK_W-1:0];
        end
      end
    end else if (w.cmd == CMD_READ) begin
      r.slot = w.rank;
      if (w.rank >= NLIST || rank_ratio[w.rank] == 0) r.status = ST_NOT_RANK;
      else begin
        r.entry_valid = 1;
        r.ratio = rank_ratio[w.rank];
        r.out_link = rank_rec[w.rank].link_id;
        r.out_from = rank_rec[w.rank].from_node;
        r.out_to = rank_rec[w.rank].to_node;
        r.out_period = rank_rec[w.rank].period;
        r.out_volume = rank_rec[w.rank].volume;
        r.out_capacity = rank_rec[w.rank].capacity;
      end
    end else if (w.cmd == CMD_CLEAR) begin
      for (int i = 0; i < NLIST; i++) rank_ratio[i] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_cnt++;
    if (err_cnt <= 40) $display("%t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // send one word, holding until accepted; valid stays up for the next word
  task automatic send_word(req_word_t w);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.cmd, in_ch.link_id, in_ch.from_node, in_ch.to_node, in_ch.period,
     in_ch.volume, in_ch.capacity, in_ch.rank} <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (check_row) begin
      void'(rank_update(w));
      pending_rsp.push_back(row_rsp);
    end else
      pending_rsp.push_back(rank_update(w));
    word_cnt++;
  endtask

  // receiver: random stall, check each accepted word
  always @(posedge clk) begin
    rsp_word_t got, want;
    if (rst) out_ch.ready <= 0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.slot, out_ch.entry_valid, out_ch.ratio,
               out_ch.out_link, out_ch.out_from, out_ch.out_to, out_ch.out_period,
               out_ch.out_volume, out_ch.out_capacity};
        rsp_cnt++;
        if (pending_rsp.size() == 0) report_mismatch("unexpected word", 1, 0);
        else begin
          want = pending_rsp.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
          if (got.entry_valid != want.entry_valid)
            report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
          if (got.ratio != want.ratio) report_mismatch("ratio", got.ratio, want.ratio);
          if (got.out_link != want.out_link) report_mismatch("link", got.out_link, want.out_link);
          if (got.out_from != want.out_from) report_mismatch("from", got.out_from, want.out_from);
          if (got.out_to != want.out_to) report_mismatch("to", got.out_to, want.out_to);
          if (got.out_period != want.out_period)
            report_mismatch("period", got.out_period, want.out_period);
          if (got.out_volume != want.out_volume)
            report_mismatch("volume", got.out_volume, want.out_volume);
          if (got.out_capacity != want.out_capacity)
            report_mismatch("capacity", got.out_capacity, want.out_capacity);
        end
      end
      out_ch.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  function automatic req_word_t mk(logic [1:0] c, int lk, int vol, int cap, int rk);
    req_word_t w;
    w = '0;
    w.cmd = c;
    w.link_id = ID_W'(lk);
    w.from_node = ID_W'(~lk);
    w.to_node = ID_W'(lk) ^ 24'h5a5a5a;
    w.period = lk[7:0];
    w.volume = VAL_W'(vol);
    w.capacity = VAL_W'(cap);
    w.rank = RANK_W'(rk);
    return w;
  endfunction

  // random word: mostly offers and reads of ranks up to two past the fill count
  function automatic req_word_t rand_word();
    req_word_t w;
    int p;
    w.cmd = CMD_OFFER;
    w.link_id = ID_W'($urandom);
    w.from_node = ID_W'($urandom);
    w.to_node = ID_W'($urandom);
    w.period = PER_W'($urandom);
    w.rank = RANK_W'($urandom_range(fill_cnt + 2 > 127 ? 127 : fill_cnt + 2));
    p = $urandom_range(99);
    case ($urandom_range(9))
      0: w.volume = '0;
      1: w.volume = VAL_W'($urandom);
      default: w.volume = VAL_W'($urandom_range(2000));
    endcase
    case ($urandom_range(9))
      0: w.capacity = '0;
      1: w.capacity = VAL_W'($urandom);
      default: w.capacity = VAL_W'($urandom_range(1, 3000));
    endcase
    if (p < 55) w.cmd = CMD_OFFER;
    else if (p < 95) w.cmd = CMD_READ;
    else if (p < 98) w.cmd = CMD_CLEAR;
    else w.cmd = CMD_SPARE;
    return w;
  endfunction

  typedef struct {
    req_word_t w;
    bit        fixed;
    rsp_word_t r;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    req_word_t w;
    int i;
    in_ch.valid = 0;
    {in_ch.cmd, in_ch.link_id, in_ch.from_node, in_ch.to_node, in_ch.period,
     in_ch.volume, in_ch.capacity, in_ch.rank} = '0;
    rst = 1;
    for (i = 0; i < NLIST; i++) begin
      rank_ratio[i] = '0;
      rank_rec[i] = '0;
    end
    send_idle = 0;
    recv_stall = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed rows
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 1, '{ST_NOT_RANK, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 127), 1,
                     '{ST_NOT_RANK, 127, 0, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{mk(CMD_OFFER, 1, 0, 5, 0), 1, '{ST_ZERO_VOL, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{mk(CMD_OFFER, 2, 5, 0, 0), 1, '{ST_ZERO_CAP, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{mk(CMD_OFFER, 3, 1, 65535, 0), 1,
                     '{ST_NOT_RANK, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{mk(CMD_OFFER, 24'hffffff, 65535, 1, 0), 1,
                     '{ST_OK, 0, 0, 6553500, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{mk(CMD_OFFER, 5, 3, 2, 0), 0, '0});
    rows.push_back('{mk(CMD_OFFER, 6, 3, 2, 0), 0, '0});
    rows.push_back('{mk(CMD_OFFER, 7, 65535, 65535, 0), 0, '0});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 2), 0, '0});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 99), 0, '0});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 100), 0, '0});
    rows.push_back('{mk(CMD_SPARE, 9, 9, 9, 1), 1, '0});
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0), 1, '0});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 1, '{ST_NOT_RANK, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
    foreach (rows[j]) begin
      check_row = rows[j].fixed;
      row_rsp = rows[j].r;
      send_word(rows[j].w);
    end
    check_row = 0;

    // offers with a read every tenth word, to fill the list toward its size
    for (i = 0; i < 110; i++) begin
      w = rand_word();
      w.cmd = CMD_OFFER;
      w.volume = VAL_W'($urandom_range(1, 300));
      w.capacity = VAL_W'($urandom_range(1, 300));
      if (i % 10 == 9) begin w.cmd = CMD_READ; w.rank = RANK_W'($urandom_range(99)); end
      send_word(w);
    end

    // random phases: free, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 70 : (ph == 3) ? 37 : 0;
      recv_stall = (ph == 2) ? 70 : (ph == 3) ? 37 : 0;
      for (i = 0; i < 270; i++) begin
        w = rand_word();
        if (w.cmd == CMD_OFFER) fill_cnt = fill_cnt < NLIST ? fill_cnt + 1 : NLIST;
        if (w.cmd == CMD_CLEAR) fill_cnt = 0;
        send_word(w);
      end
    end
    in_ch.valid <= 0;

    i = 0;
    while (pending_rsp.size() != 0 && i < 200000) begin
      @(posedge clk);
      i++;
    end
    repeat (300) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d mismatches", word_cnt, rsp_cnt, err_cnt);
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_rsp.size() != 0) $display("%0d results never arrived", pending_rsp.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
